// ----- src/heartbeat_watchdog_table_top_defines.svh -----
// Assertion macros for the heartbeat watchdog table.
// Included by the top level; depends on nothing else.
`ifndef HEARTBEAT_WATCHDOG_TABLE_TOP_DEFINES_SVH
`define HEARTBEAT_WATCHDOG_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define HWT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define HWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hwt_pkg.sv -----
// Shared types and codes for the heartbeat watchdog table.
// No dependencies; used by the age unit and the top level.
package hwt_pkg;

  localparam int TIME_W = 32;

  // Request kinds.
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_REGISTER = 3'd1;
  localparam logic [2:0] KIND_BEAT     = 3'd2;
  localparam logic [2:0] KIND_SNAPSHOT = 3'd3;
  localparam logic [2:0] KIND_CHECK    = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ARG   = 2'd1;
  localparam logic [1:0] ST_BAD_STATE = 2'd2;

  // Operands handed to the shared age unit.
  typedef struct packed {
    logic              en;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] beat;
    logic [TIME_W-1:0] limit;
  } age_req_t;

  // Registered answer of the shared age unit.
  typedef struct packed {
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] limit;
    logic              late;
  } age_rsp_t;

endpackage

// ----- src/hwt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/hwt_age_unit.sv -----
// Shared age unit: wrapping elapsed time and overdue compare, registered.
// Depends on hwt_pkg.
module hwt_age_unit
  import hwt_pkg::*;
(
  input  logic     clk,
  input  age_req_t req,
  output age_rsp_t rsp
);

  logic [TIME_W-1:0] age_next;

  // Age wraps modulo 2^32, so a plain subtract is exact.
  assign age_next = req.now - req.beat;

  // Capture age, limit and the strict overdue compare.
  always_ff @(posedge clk) begin
    if (req.en) begin
      rsp.age   <= age_next;
      rsp.limit <= req.limit;
      rsp.late  <= (age_next > req.limit);
    end
  end

endmodule

// ----- src/heartbeat_watchdog_table_top.sv -----
// Heartbeat watchdog table top level: request decode, sequencer, table storage.
// Depends on hwt_pkg, hwt_ram, hwt_age_unit and the assertion defines header.
`include "heartbeat_watchdog_table_top_defines.svh"

// The block holds NUM_ENTRIES watched entries and a wrapping 32-bit
// millisecond counter advanced by tick requests. One request is taken at a
// time. Tick, register, heartbeat and rejected requests go straight to the
// done state; a snapshot reads its entry and passes wait and evaluate; a
// check passes issue, wait and evaluate for each entry, reading it from the
// table memories and running it through the single age unit in turn: read,
// subtract and compare, then fold into the healthy flag. A finished result
// waits in the output register, and a new request is taken while it waits.
// Valid flags are cleared by reset; the table memories need no clearing.
module heartbeat_watchdog_table_top
  import hwt_pkg::*;
#(
  parameter int NUM_ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [2:0]        kind,
  input  logic [7:0]        entry_id,
  input  logic [31:0]       timeout,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [1:0]        status,
  output logic              all_healthy,
  output logic [31:0]       age_ms,
  output logic [31:0]       entry_timeout,
  output logic              overdue
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [8:0] ID_LIMIT = 9'(NUM_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_EVAL,
    S_DONE
  } state_t;

  state_t state;

  logic [TIME_W-1:0]      now_counter;
  logic [NUM_ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]       idx;
  logic                   op_check;

  // Result being built for the output register.
  logic [1:0]        res_status;
  logic              res_healthy;
  logic [TIME_W-1:0] res_age;
  logic [TIME_W-1:0] res_limit;
  logic              res_late;

  logic              accept;
  logic              id_ok;
  logic [IDX_W-1:0]  id_idx;
  logic              reg_ok;
  logic              beat_ok;
  logic              snap_ok;
  logic              beat_we;
  logic              lim_we;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [TIME_W-1:0] beat_rd;
  logic [TIME_W-1:0] lim_rd;
  logic              rsp_free;
  logic [1:0]        dec_status;
  state_t            dec_state;
  age_req_t          age_req;
  age_rsp_t          age_rsp;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Request decode.
  assign id_ok   = ({1'b0, entry_id} < ID_LIMIT);
  assign id_idx  = entry_id[IDX_W-1:0];
  assign reg_ok  = id_ok && (timeout != '0) && !entry_valid[id_idx];
  assign beat_ok = id_ok && entry_valid[id_idx];
  assign snap_ok = id_ok && entry_valid[id_idx];

  // Status of the incoming request and the state it moves the sequencer to.
  always_comb begin
    dec_status = ST_OK;
    dec_state  = S_DONE;
    case (kind)
      KIND_TICK: begin
      end
      KIND_REGISTER: begin
        if (!id_ok || (timeout == '0)) begin
          dec_status = ST_BAD_ARG;
        end else if (entry_valid[id_idx]) begin
          dec_status = ST_BAD_STATE;
        end
      end
      KIND_BEAT: begin
        if (!beat_ok) begin
          dec_status = ST_BAD_ARG;
        end
      end
      KIND_SNAPSHOT: begin
        if (!id_ok) begin
          dec_status = ST_BAD_ARG;
        end else if (!entry_valid[id_idx]) begin
          dec_status = ST_BAD_STATE;
        end else begin
          dec_state = S_WAIT;
        end
      end
      KIND_CHECK: begin
        dec_state = S_ISSUE;
      end
      default: begin
        dec_status = ST_BAD_ARG;
      end
    endcase
  end

  // Table writes happen in the accept cycle.
  assign beat_we = accept && (((kind == KIND_REGISTER) && reg_ok) ||
                              ((kind == KIND_BEAT) && beat_ok));
  assign lim_we  = accept && (kind == KIND_REGISTER) && reg_ok;

  // Table reads: the request's entry for a snapshot, the scan index for a check.
  assign rd_en   = (accept && (kind == KIND_SNAPSHOT) && snap_ok) || (state == S_ISSUE);
  assign rd_addr = (state == S_IDLE) ? id_idx : idx;

  hwt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_ENTRIES)) u_beat_ram (
    .clk   (clk),
    .we    (beat_we),
    .waddr (id_idx),
    .wdata (now_counter),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (beat_rd)
  );

  hwt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_ENTRIES)) u_limit_ram (
    .clk   (clk),
    .we    (lim_we),
    .waddr (id_idx),
    .wdata (timeout),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (lim_rd)
  );

  // The age unit takes read data in the cycle after the read is issued.
  assign age_req.en    = (state == S_WAIT);
  assign age_req.now   = now_counter;
  assign age_req.beat  = beat_rd;
  assign age_req.limit = lim_rd;

  hwt_age_unit u_age (
    .clk (clk),
    .req (age_req),
    .rsp (age_rsp)
  );

  // Sequencer, table flags, counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      now_counter <= '0;
      entry_valid <= '0;
      idx         <= '0;
      op_check    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      // The output is set when a finished result is loaded and cleared when taken.
      if ((state == S_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_status  <= dec_status;
            res_healthy <= (kind == KIND_CHECK);
            res_age     <= '0;
            res_limit   <= '0;
            res_late    <= 1'b0;
            op_check    <= (kind == KIND_CHECK);
            idx         <= '0;
            state       <= dec_state;
            if (kind == KIND_TICK) begin
              now_counter <= now_counter + 1'b1;
            end
            if (lim_we) begin
              entry_valid[id_idx] <= 1'b1;
            end
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (op_check) begin
            if (entry_valid[idx] && age_rsp.late) begin
              res_healthy <= 1'b0;
            end
            if (idx == LAST_IDX) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_ISSUE;
            end
          end else begin
            res_age   <= age_rsp.age;
            res_limit <= age_rsp.limit;
            res_late  <= age_rsp.late;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            status        <= res_status;
            all_healthy   <= res_healthy;
            age_ms        <= res_age;
            entry_timeout <= res_limit;
            overdue       <= res_late;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A tick request advances the counter by exactly one.
  `HWT_ASSERT_NEXT(a_tick_advances, accept && (kind == KIND_TICK), now_counter == $past(now_counter) + 1'b1, "tick did not advance the counter")

  // Registered entries are never dropped.
  `HWT_ASSERT_NEXT(a_valid_kept, 1'b1, (entry_valid & $past(entry_valid)) == $past(entry_valid), "a registered entry lost its valid flag")

  // A finished result is loaded into a free output register and the block goes idle.
  `HWT_ASSERT_NEXT(a_result_loaded, (state == S_DONE) && rsp_free, rsp_valid && (state == S_IDLE), "finished result was not presented")

endmodule
